/* hdl/modbus_rtu_read_response_checker_core_defines.svh */
// Assertion macros for the Modbus RTU read response checker
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_CORE_DEFINES_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MRRC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MRRC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mrrc_pkg.sv */
// Shared types, constants and CRC function for the Modbus RTU read response checker
package mrrc_pkg;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  FUNC_READ      = 8'h03;
	localparam logic [7:0]  FUNC_EXCEPTION = 8'h83;
	localparam logic [3:0]  MIN_LAST_IDX   = 4'd4;
	localparam logic [3:0]  COUNT_MAX      = 4'd15;

	localparam logic [1:0]  REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0]  REG_WORD_COUNT    = 2'd1;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_ADDR   = 3'd2,
		ST_EXCEPT = 3'd3,
		ST_FUNC   = 3'd4,
		ST_CRC    = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] first_word;
		logic [15:0] second_word;
	} result_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* hdl/mrrc_frame.sv */
// Frame state, CRC accumulation and end-of-frame checks
module mrrc_frame
	import mrrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	input  logic [7:0]  slave_address,
	input  logic [1:0]  word_count,
	output result_t     result
);

`include "modbus_rtu_read_response_checker_core_defines.svh"

	logic [3:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  trail_q [2];
	logic [7:0]  hdr_q [2];
	logic [7:0]  pay_q [4];

	logic [3:0]  cnt_n;
	logic [15:0] crc_n;
	logic [7:0]  trail_n [2];
	logic [7:0]  hdr_n [2];
	logic [7:0]  pay_n [4];
	status_t     status_n;

	always_comb begin
		hdr_n = hdr_q;
		pay_n = pay_q;
		if (cnt_q == 4'd0) begin
			hdr_n[0] = rx_byte;
			hdr_n[1] = 8'h00;
			for (int i = 0; i < 4; i++) begin
				pay_n[i] = 8'h00;
			end
		end else if (cnt_q == 4'd1) begin
			hdr_n[1] = rx_byte;
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (cnt_q == 4'(i + 3)) begin
					pay_n[i] = rx_byte;
				end
			end
		end
		crc_n = (cnt_q >= 4'd2) ? crc_update(crc_q, trail_q[0]) : crc_q;
		trail_n[0] = trail_q[1];
		trail_n[1] = rx_byte;
		cnt_n = (cnt_q < COUNT_MAX) ? cnt_q + 4'd1 : cnt_q;
	end

	always_comb begin
		priority if (cnt_q < MIN_LAST_IDX) begin
			status_n = ST_SHORT;
		end else if (hdr_n[0] != slave_address) begin
			status_n = ST_ADDR;
		end else if (hdr_n[1] == FUNC_EXCEPTION) begin
			status_n = ST_EXCEPT;
		end else if (hdr_n[1] != FUNC_READ) begin
			status_n = ST_FUNC;
		end else if (crc_n != {trail_n[1], trail_n[0]}) begin
			status_n = ST_CRC;
		end else begin
			status_n = ST_OK;
		end
	end

	always_comb begin
		result.status      = status_n;
		result.first_word  = 16'h0000;
		result.second_word = 16'h0000;
		if (status_n == ST_OK) begin
			result.first_word = {pay_n[0], pay_n[1]};
			if (word_count[1]) begin
				result.second_word = {pay_n[2], pay_n[3]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			crc_q <= CRC_INIT;
			trail_q[0] <= 8'h00;
			trail_q[1] <= 8'h00;
			hdr_q[0] <= 8'h00;
			hdr_q[1] <= 8'h00;
			for (int i = 0; i < 4; i++) begin
				pay_q[i] <= 8'h00;
			end
		end else if (step) begin
			if (last_byte) begin
				cnt_q <= 4'd0;
				crc_q <= CRC_INIT;
				trail_q[0] <= 8'h00;
				trail_q[1] <= 8'h00;
				hdr_q[0] <= 8'h00;
				hdr_q[1] <= 8'h00;
				for (int i = 0; i < 4; i++) begin
					pay_q[i] <= 8'h00;
				end
			end else begin
				cnt_q <= cnt_n;
				crc_q <= crc_n;
				trail_q <= trail_n;
				hdr_q <= hdr_n;
				pay_q <= pay_n;
			end
		end
	end

	`MRRC_ASSERT_NXT(a_frame_restart, step && last_byte, cnt_q == 4'd0 && crc_q == CRC_INIT, "frame state not cleared after last byte")
	`MRRC_ASSERT_NXT(a_count_moves, step && !last_byte && cnt_q < COUNT_MAX, cnt_q == $past(cnt_q) + 4'd1, "byte counter did not advance")
	`MRRC_ASSERT_NXT(a_count_holds, !step, $stable(cnt_q) && $stable(crc_q), "frame state changed without a step")

endmodule

/* hdl/modbus_rtu_read_response_checker_core.sv */
// Top level of the Modbus RTU read response checker
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    rx_byte, last_byte
//   out      out  out_valid / out_stall  status, first_word, second_word
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// One byte per cycle sustained, unless a last byte waits on a full, stalled result register.
// The input register feeds the CRC and check logic, which loads the result register.
// A pending last byte waits in the input register while the result register is full and stalled.
// Reset clears the frame state and sets slave_address to 1 and word_count to 1.
module modbus_rtu_read_response_checker_core
	import mrrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] first_word,
	output logic [15:0] second_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

`include "modbus_rtu_read_response_checker_core_defines.svh"

	logic [7:0]  slave_address_q;
	logic [1:0]  word_count_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic        out_valid_q;
	result_t     out_q;

	logic        out_free;
	logic        step;
	result_t     result;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			word_count_q <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE_ADDRESS: slave_address_q <= cfg_data;
				REG_WORD_COUNT:    word_count_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
	end

	mrrc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (byte_s1),
		.last_byte     (last_s1),
		.slave_address (slave_address_q),
		.word_count    (word_count_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && last_s1) begin
			out_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign first_word  = out_q.first_word;
	assign second_word = out_q.second_word;

	`MRRC_ASSERT_IMP(a_unused_words_zero, out_valid_q && out_q.status != ST_OK, out_q.first_word == 16'h0000 && out_q.second_word == 16'h0000, "words not zero on failing status")
	`MRRC_ASSERT_IMP(a_stall_has_item, in_stall, valid_s1 && last_s1 && out_valid_q, "input stalled without a blocked last byte")
	`MRRC_ASSERT_NXT(a_held_byte_kept, in_stall, valid_s1 && $stable(byte_s1), "stalled input byte lost")
	`MRRC_ASSERT_IMP(a_status_range, out_valid_q, out_q.status <= ST_CRC, "status code out of range")

endmodule
